// ===== sv/xref_stream_row_decoder_unit_macros.svh =====
// Assertion macros shared by the cross-reference row decoder RTL.
`ifndef XREF_STREAM_ROW_DECODER_UNIT_MACROS_SVH
`define XREF_STREAM_ROW_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on aclk, skipped while aresetn is low.
`define XSRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on aclk, also during reset.
`define XSRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define XSRD_ASSERT(lbl, prop, msg)
`define XSRD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/xsrd_pkg.sv =====
// Types and constants of the cross-reference row decoder.
package xsrd_pkg;

    localparam int CFG_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int VALUE_W    = 32;
    localparam int ROW_SUM_W  = 5;   // holds three widths of up to 7 bytes each

    localparam logic [1:0] CMD_DATA       = 2'd0;
    localparam logic [1:0] CMD_SUBSECTION = 2'd1;
    localparam logic [1:0] CMD_NEW_STREAM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_WIDTH  = 2'd2;

    localparam logic [CFG_W-1:0] TYPE_WIDTH_RST   = 3'd1;
    localparam logic [CFG_W-1:0] SECOND_WIDTH_RST = 3'd4;
    localparam logic [CFG_W-1:0] THIRD_WIDTH_RST  = 3'd2;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        KIND_FREE       = 2'd0,
        KIND_NORMAL     = 2'd1,
        KIND_COMPRESSED = 2'd2,
        KIND_UNKNOWN    = 2'd3
    } entry_kind_t;

    // Field widths in bytes, already clamped.
    typedef struct packed {
        logic [CFG_W-1:0] type_width;
        logic [CFG_W-1:0] second_width;
        logic [CFG_W-1:0] third_width;
    } field_widths_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] object_number;
        entry_kind_t        entry_kind;
        logic [VALUE_W-1:0] second_value;
        logic [VALUE_W-1:0] third_value;
    } row_result_t;

endpackage

// ===== sv/xref_stream_row_decoder_unit.sv =====
// Top level of the cross-reference stream row decoder.
// Usage:
//   s_ channel carries one request per cycle: a data byte, a subsection start
//   (first object number and entry count, zero count meaning unlimited) or a
//   new-stream marker, selected by s_tuser. Each completed row of three
//   big-endian fields yields one request on the m_ channel with the object
//   number, the entry kind in m_tuser and the second and third field values.
//   Rows past the end of a counted subsection are dropped.
//   cfg_ channel writes the three field widths in bytes; it is always ready, and
//   the user must write it only while the decoder is idle; the block itself does not enforce that.
// Timing and throughput:
//   A result is registered and appears on m_ in the cycle after the byte completing its row.
//   One request is accepted every cycle while m_ is not stalled; the rate is set
//   by the single accumulate-and-count stage feeding the output register.
// Reset:
//   aresetn low clears the partial row, numbering starts at 0 unlimited,
//   and the widths return to 1, 4 and 2 bytes.
// Stall:
//   While m_tready is low with a result pending, s_tready drops and the
//   pending result holds.
`include "xref_stream_row_decoder_unit_macros.svh"

module xref_stream_row_decoder_unit #(
    parameter int MAX_FIELD_BYTES = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [71:0]                    s_tdata,   // data_byte, first_object, entry_count
    input  logic [1:0]                     s_tuser,   // cmd
    // result requests
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,   // object_number, second_value, third_value
    output logic [1:0]                     m_tuser,   // entry_kind
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xsrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xsrd_pkg::CFG_W-1:0]     cfg_data
);
    import xsrd_pkg::*;

    field_widths_t      widths;
    row_result_t        row_res;
    logic               s_accept;

    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] obj_reg, second_reg, third_reg;
    entry_kind_t        kind_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    xsrd_cfg #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .widths    (widths)
    );

    xsrd_row #(
        .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
    ) u_row (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .cmd          (s_tuser),
        .data_byte    (s_tdata[7:0]),
        .first_object (s_tdata[39:8]),
        .entry_count  (s_tdata[71:40]),
        .widths       (widths),
        .result       (row_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (row_res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload loads only with a new row; hold otherwise.
    always_ff @(posedge aclk) begin
        if (row_res.valid) begin
            obj_reg    <= row_res.object_number;
            kind_reg   <= row_res.entry_kind;
            second_reg <= row_res.second_value;
            third_reg  <= row_res.third_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {third_reg, second_reg, obj_reg};
    assign m_tuser  = kind_reg;

    `XSRD_ASSERT(a_row_reaches_output, row_res.valid |=> m_tvalid, "completed row not presented")
    `XSRD_ASSERT(a_result_from_request, $rose(m_tvalid) |-> $past(s_accept), "result without an input request")
    `XSRD_ASSERT(a_stalled_result_kept, m_tvalid && !m_tready |=> m_tvalid, "pending result lost under stall")
    `XSRD_ASSERT_ALWAYS(a_reset_empties_output, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

// ===== sv/xsrd_cfg.sv =====
// Field width registers with clamping to the largest supported field.
module xsrd_cfg #(
    parameter int MAX_FIELD_BYTES = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xsrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xsrd_pkg::CFG_W-1:0]     cfg_data,
    output xsrd_pkg::field_widths_t        widths
);
    import xsrd_pkg::*;

    localparam logic [CFG_W-1:0] MAX_W =
        (MAX_FIELD_BYTES > 7) ? 3'd7 : CFG_W'(MAX_FIELD_BYTES);

    logic [CFG_W-1:0] type_width_reg;
    logic [CFG_W-1:0] second_width_reg;
    logic [CFG_W-1:0] third_width_reg;

    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        return (w > MAX_W) ? MAX_W : w;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_width_reg   <= TYPE_WIDTH_RST;
            second_width_reg <= SECOND_WIDTH_RST;
            third_width_reg  <= THIRD_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TYPE_WIDTH:   type_width_reg   <= cfg_data;
                REG_SECOND_WIDTH: second_width_reg <= cfg_data;
                REG_THIRD_WIDTH:  third_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign widths.type_width   = clamp_width(type_width_reg);
    assign widths.second_width = clamp_width(second_width_reg);
    assign widths.third_width  = clamp_width(third_width_reg);

endmodule

// ===== sv/xsrd_row.sv =====
// Row assembly state, subsection numbering and row result decode.
`include "xref_stream_row_decoder_unit_macros.svh"

module xsrd_row #(
    parameter int MAX_FIELD_BYTES = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [1:0]                   cmd,
    input  logic [7:0]                   data_byte,
    input  logic [xsrd_pkg::VALUE_W-1:0] first_object,
    input  logic [xsrd_pkg::VALUE_W-1:0] entry_count,
    input  xsrd_pkg::field_widths_t      widths,
    output xsrd_pkg::row_result_t        result
);
    import xsrd_pkg::*;

    localparam int POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] type_acc_reg, type_acc_next;
    logic [VALUE_W-1:0] second_acc_reg, second_acc_next;
    logic [VALUE_W-1:0] third_acc_reg, third_acc_next;
    logic [VALUE_W-1:0] next_object_reg, next_object_next;
    logic [VALUE_W-1:0] entries_left_reg, entries_left_next;
    logic               live_reg, live_next;

    logic [ROW_SUM_W-1:0] tw, sw, hw, row_size, pos_ext, pos_inc;
    logic [VALUE_W-1:0]   type_upd, second_upd, third_upd, type_value;
    logic [VALUE_W-1:0]   shifted;
    logic                 take_byte, row_done;
    entry_kind_t          kind;

    assign tw       = ROW_SUM_W'(widths.type_width);
    assign sw       = ROW_SUM_W'(widths.second_width);
    assign hw       = ROW_SUM_W'(widths.third_width);
    assign row_size = tw + sw + hw;
    assign pos_ext  = ROW_SUM_W'(pos_reg);
    assign pos_inc  = pos_ext + ROW_SUM_W'(1);

    assign take_byte = accept && (cmd == CMD_DATA) && (row_size != '0);
    assign row_done  = take_byte && (pos_inc >= row_size);

    // Route the byte by position; anything past the first two fields goes to the third.
    always_comb begin
        shifted    = 'x;
        type_upd   = type_acc_reg;
        second_upd = second_acc_reg;
        third_upd  = third_acc_reg;
        if (pos_ext < tw) begin
            shifted  = {type_acc_reg[VALUE_W-9:0], data_byte & BYTE_MASK};
            type_upd = shifted;
        end else if (pos_ext < tw + sw) begin
            shifted    = {second_acc_reg[VALUE_W-9:0], data_byte & BYTE_MASK};
            second_upd = shifted;
        end else begin
            shifted   = {third_acc_reg[VALUE_W-9:0], data_byte & BYTE_MASK};
            third_upd = shifted;
        end
    end

    // A row without a type field is a normal entry.
    assign type_value = (tw == '0) ? VALUE_W'(1) : type_upd;

    always_comb begin
        case (type_value)
            VALUE_W'(0): kind = KIND_FREE;
            VALUE_W'(1): kind = KIND_NORMAL;
            VALUE_W'(2): kind = KIND_COMPRESSED;
            default:     kind = KIND_UNKNOWN;
        endcase
    end

    assign result.valid         = row_done && live_reg;
    assign result.object_number = next_object_reg;
    assign result.entry_kind    = kind;
    assign result.second_value  = second_upd;
    assign result.third_value   = third_upd;

    always_comb begin
        pos_next          = pos_reg;
        type_acc_next     = type_acc_reg;
        second_acc_next   = second_acc_reg;
        third_acc_next    = third_acc_reg;
        next_object_next  = next_object_reg;
        entries_left_next = entries_left_reg;
        live_next         = live_reg;
        if (accept) begin
            case (cmd)
                CMD_SUBSECTION: begin
                    next_object_next  = first_object;
                    entries_left_next = entry_count;
                    live_next         = 1'b1;
                end
                CMD_NEW_STREAM: begin
                    pos_next          = '0;
                    type_acc_next     = '0;
                    second_acc_next   = '0;
                    third_acc_next    = '0;
                    next_object_next  = '0;
                    entries_left_next = '0;
                    live_next         = 1'b1;
                end
                CMD_DATA: begin
                    if (row_done) begin
                        pos_next        = '0;
                        type_acc_next   = '0;
                        second_acc_next = '0;
                        third_acc_next  = '0;
                        if (live_reg) begin
                            next_object_next = next_object_reg + VALUE_W'(1);
                            if (entries_left_reg != '0) begin
                                entries_left_next = entries_left_reg - VALUE_W'(1);
                                // drop rows once a counted subsection runs out
                                if (entries_left_reg == VALUE_W'(1)) begin
                                    live_next = 1'b0;
                                end
                            end
                        end
                    end else if (take_byte) begin
                        pos_next        = POS_W'(pos_inc);
                        type_acc_next   = type_upd;
                        second_acc_next = second_upd;
                        third_acc_next  = third_upd;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            type_acc_reg     <= '0;
            second_acc_reg   <= '0;
            third_acc_reg    <= '0;
            next_object_reg  <= '0;
            entries_left_reg <= '0;
            live_reg         <= 1'b1;
        end else begin
            pos_reg          <= pos_next;
            type_acc_reg     <= type_acc_next;
            second_acc_reg   <= second_acc_next;
            third_acc_reg    <= third_acc_next;
            next_object_reg  <= next_object_next;
            entries_left_reg <= entries_left_next;
            live_reg         <= live_next;
        end
    end

    `XSRD_ASSERT(a_new_stream_clears_row, accept && (cmd == CMD_NEW_STREAM) |=> (pos_reg == '0) && live_reg && (next_object_reg == '0), "new stream did not restore numbering")
    `XSRD_ASSERT(a_last_entry_drops_live, result.valid && (entries_left_reg == VALUE_W'(1)) |=> !live_reg, "subsection did not close after its last row")
    `XSRD_ASSERT(a_emit_advances_object, result.valid |=> (next_object_reg == $past(next_object_reg) + VALUE_W'(1)), "object number did not advance after a row")

endmodule
